@@ src/battery_pack_cell_statistics_top_assert.svh @@
// ----------------------------------------------------------------------------
// battery_pack_cell_statistics_top_assert.svh
// assertion macros used by the checker file of the cell statistics block
// ----------------------------------------------------------------------------
`ifndef BATTERY_PACK_CELL_STATISTICS_TOP_ASSERT_SVH
`define BATTERY_PACK_CELL_STATISTICS_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BPCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BPCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bpcs_pkg.sv @@
// ----------------------------------------------------------------------------
// bpcs_pkg
// shared constants, widths and beat types of the cell statistics block
// ----------------------------------------------------------------------------
package bpcs_pkg;

    // pack configuration
    localparam int unsigned DEVICES     = 6;
    localparam int unsigned PACK_CELLS  = 36;
    localparam int unsigned SCALE_MUL   = 6250;
    localparam int unsigned SCALE_DIV   = 16383;

    // field widths
    localparam int unsigned RAW_W = 14;
    localparam int unsigned CRC_W = 16;
    localparam int unsigned MV_W  = 13;
    localparam int unsigned SUM_W = 20;
    localparam int unsigned AVG_W = 16;
    localparam int unsigned NUM_W = 7;
    localparam int unsigned DEV_W = 4;

    // saturation limits, the last device index and the first cell number
    localparam logic [MV_W-1:0]  MV_MAX   = '1;
    localparam logic [SUM_W-1:0] SUM_MAX  = '1;
    localparam logic [AVG_W-1:0] AVG_MAX  = '1;
    localparam logic [DEV_W-1:0] DEV_LAST = DEV_W'(DEVICES - 1);
    localparam logic [NUM_W-1:0] NUM_FIRST = NUM_W'(1);

    // scaling: code * SCALE_MUL, then exact floor division by reciprocal
    localparam longint unsigned PROD_MAX = ((64'd1 << RAW_W) - 64'd1) * 64'(SCALE_MUL);
    localparam int unsigned PROD_W = $clog2(PROD_MAX + 64'd1);
    localparam int unsigned SCL_SH = PROD_W + $clog2(SCALE_DIV);
    localparam logic [63:0] SCL_RECIP =
        ((64'd1 << SCL_SH) + 64'(SCALE_DIV) - 64'd1) / 64'(SCALE_DIV);
    localparam int unsigned SCL_RW = PROD_W + 1;
    localparam int unsigned RP_W   = PROD_W + SCL_RW;
    localparam logic [SCL_RW-1:0] SCL_K = SCL_RECIP[SCL_RW-1:0];

    // average: exact floor division of the pack sum by reciprocal
    localparam int unsigned AVG_SH = SUM_W + $clog2(PACK_CELLS);
    localparam logic [63:0] AVG_RECIP =
        ((64'd1 << AVG_SH) + 64'(PACK_CELLS) - 64'd1) / 64'(PACK_CELLS);
    localparam int unsigned AVG_RW = SUM_W + 1;
    localparam int unsigned AP_W   = SUM_W + AVG_RW;
    localparam logic [AVG_RW-1:0] AVG_K = AVG_RECIP[AVG_RW-1:0];

    // cell beat as captured at the input
    typedef struct packed {
        logic [RAW_W-1:0] raw;
        logic [CRC_W-1:0] crc;
        logic             dev_end;
        logic             pack_end;
    } t_cell_raw;

    // side fields that travel with a cell through the scaling stages
    typedef struct packed {
        logic [CRC_W-1:0] crc;
        logic             dev_end;
        logic             pack_end;
    } t_tag;

    // scaled cell beat
    typedef struct packed {
        logic [MV_W-1:0] mv;
        t_tag            tag;
    } t_cell_mv;

    // scan summary
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [MV_W-1:0]  low;
        logic [MV_W-1:0]  high;
        logic [NUM_W-1:0] low_num;
        logic [NUM_W-1:0] high_num;
        logic [CRC_W-1:0] crc_best;
        logic [DEV_W-1:0] crc_dev;
    } t_stats;

endpackage

@@ src/bpcs_scale.sv @@
// ----------------------------------------------------------------------------
// bpcs_scale
// three-stage pipeline turning a raw cell code into saturated millivolts
// ----------------------------------------------------------------------------
module bpcs_scale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  bpcs_pkg::t_cell_raw i_cell,
    output logic                o_valid,
    input  logic                i_stall,
    output bpcs_pkg::t_cell_mv  o_cell
);
    import bpcs_pkg::*;

    logic                r_v2, r_v3, r_v4;
    logic                ld2, ld3, ld4;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [RP_W-1:0]     r_rprod, n_rprod;
    t_tag                r_tag2, r_tag3;
    t_cell_mv            r_cell, n_cell;
    logic [PROD_W-1:0]   quot;

    // stage advance: a stage loads when empty or when it drains downstream
    assign ld4     = !r_v4 || !i_stall;
    assign ld3     = !r_v3 || ld4;
    assign ld2     = !r_v2 || ld3;
    assign o_stall = !ld2;

    // code times the scale multiplier
    assign n_prod = PROD_W'(i_cell.raw) * PROD_W'(SCALE_MUL);

    // product times the reciprocal of the divider
    assign n_rprod = RP_W'(r_prod) * RP_W'(SCL_K);

    // shift out the quotient and saturate to the millivolt range
    always_comb begin
        quot        = PROD_W'(r_rprod >> SCL_SH);
        n_cell.tag  = r_tag3;
        if (quot > PROD_W'(MV_MAX)) begin
            n_cell.mv = MV_MAX;
        end else begin
            n_cell.mv = quot[MV_W-1:0];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ld2) r_v2 <= i_valid;
            if (ld3) r_v3 <= r_v2;
            if (ld4) r_v4 <= r_v3;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r_prod          <= n_prod;
            r_tag2.crc      <= i_cell.crc;
            r_tag2.dev_end  <= i_cell.dev_end;
            r_tag2.pack_end <= i_cell.pack_end;
        end
        if (ld3) begin
            r_rprod <= n_rprod;
            r_tag3  <= r_tag2;
        end
        if (ld4) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_v4;
    assign o_cell  = r_cell;

endmodule

@@ src/bpcs_stats.sv @@
// ----------------------------------------------------------------------------
// bpcs_stats
// scan accumulators, pack summary snapshot, average and result register
// ----------------------------------------------------------------------------
module bpcs_stats (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  bpcs_pkg::t_cell_mv i_cell,
    output logic               o_valid,
    input  logic               i_stall,
    output bpcs_pkg::t_stats   o_stats,
    output logic [bpcs_pkg::AVG_W-1:0] o_avg
);
    import bpcs_pkg::*;

    // accumulator state
    logic [SUM_W-1:0] r_sum;
    logic [MV_W-1:0]  r_low, r_high;
    logic [NUM_W-1:0] r_low_num, r_high_num, r_cell_cnt;
    logic [DEV_W-1:0] r_dev_cnt, r_crc_dev;
    logic [CRC_W-1:0] r_crc_best;
    logic             r_scan_start;

    // pipeline registers
    logic             r_v5, r_v6, r_v7;
    logic             ld5, ld6, ld7, take;
    t_stats           r_snap, r_stats6, r_stats7;
    logic [AP_W-1:0]  r_aprod, n_aprod;
    logic [AVG_W-1:0] r_avg, n_avg;
    logic [SUM_W-1:0] avg_q;

    // next accumulator values
    t_stats           n_st;
    logic [NUM_W-1:0] n_cell_cnt, base_cnt;
    logic [DEV_W-1:0] n_dev_cnt, base_dev;
    logic [SUM_W:0]   sum_ext;
    t_stats           base;

    assign ld7     = !r_v7 || !i_stall;
    assign ld6     = !r_v6 || ld7;
    assign ld5     = !r_v5 || ld6;
    assign o_stall = !ld5;
    assign take    = i_valid && ld5;

    // cell update: scan start reseeds, then sum, extremes, device close
    always_comb begin
        if (r_scan_start) begin
            base.sum      = '0;
            base.low      = i_cell.mv;
            base.high     = i_cell.mv;
            base.low_num  = NUM_FIRST;
            base.high_num = NUM_FIRST;
            base.crc_best = '0;
            base.crc_dev  = '0;
            base_cnt      = NUM_FIRST;
            base_dev      = '0;
        end else begin
            base.sum      = r_sum;
            base.low      = r_low;
            base.high     = r_high;
            base.low_num  = r_low_num;
            base.high_num = r_high_num;
            base.crc_best = r_crc_best;
            base.crc_dev  = r_crc_dev;
            base_cnt      = r_cell_cnt;
            base_dev      = r_dev_cnt;
        end

        n_st    = base;
        sum_ext = {1'b0, base.sum} + (SUM_W + 1)'(i_cell.mv);
        if (sum_ext[SUM_W]) begin
            n_st.sum = SUM_MAX;
        end else begin
            n_st.sum = sum_ext[SUM_W-1:0];
        end

        if (i_cell.mv < base.low) begin
            n_st.low     = i_cell.mv;
            n_st.low_num = base_cnt;
        end
        if (i_cell.mv > base.high) begin
            n_st.high     = i_cell.mv;
            n_st.high_num = base_cnt;
        end

        n_cell_cnt = base_cnt + NUM_W'(1);
        n_dev_cnt  = base_dev;
        if (i_cell.tag.dev_end || i_cell.tag.pack_end) begin
            if (i_cell.tag.crc > base.crc_best) begin
                n_st.crc_best = i_cell.tag.crc;
                n_st.crc_dev  = base_dev;
            end
            // numbering skips one after each device
            n_cell_cnt = base_cnt + NUM_W'(2);
            if (base_dev < DEV_LAST) begin
                n_dev_cnt = base_dev + DEV_W'(1);
            end
        end
    end

    // summary sum times reciprocal of the cell count
    assign n_aprod = AP_W'(r_snap.sum) * AP_W'(AVG_K);

    // average quotient with saturation
    always_comb begin
        avg_q = SUM_W'(r_aprod >> AVG_SH);
        if (avg_q > SUM_W'(AVG_MAX)) begin
            n_avg = AVG_MAX;
        end else begin
            n_avg = avg_q[AVG_W-1:0];
        end
    end

    // accumulator and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_low        <= '0;
            r_high       <= '0;
            r_low_num    <= '0;
            r_high_num   <= '0;
            r_cell_cnt   <= NUM_FIRST;
            r_dev_cnt    <= '0;
            r_crc_best   <= '0;
            r_crc_dev    <= '0;
            r_scan_start <= 1'b1;
            r_v5         <= 1'b0;
            r_v6         <= 1'b0;
            r_v7         <= 1'b0;
        end else begin
            if (take) begin
                r_sum        <= n_st.sum;
                r_low        <= n_st.low;
                r_high       <= n_st.high;
                r_low_num    <= n_st.low_num;
                r_high_num   <= n_st.high_num;
                r_cell_cnt   <= n_cell_cnt;
                r_dev_cnt    <= n_dev_cnt;
                r_crc_best   <= n_st.crc_best;
                r_crc_dev    <= n_st.crc_dev;
                r_scan_start <= i_cell.tag.pack_end;
            end
            // only the pack end beat carries a result onward
            if (ld5) r_v5 <= i_valid && i_cell.tag.pack_end;
            if (ld6) r_v6 <= r_v5;
            if (ld7) r_v7 <= r_v6;
        end
    end

    // summary payload registers
    always_ff @(posedge i_clk) begin
        if (ld5) r_snap <= n_st;
        if (ld6) begin
            r_stats6 <= r_snap;
            r_aprod  <= n_aprod;
        end
        if (ld7) begin
            r_stats7 <= r_stats6;
            r_avg    <= n_avg;
        end
    end

    assign o_valid = r_v7;
    assign o_stats = r_stats7;
    assign o_avg   = r_avg;

endmodule

@@ src/battery_pack_cell_statistics_top.sv @@
// ----------------------------------------------------------------------------
// battery_pack_cell_statistics_top
// pack scan statistics over scaled cell voltages and device crc counts
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_valid / o_stall) takes one cell beat per cycle while
//   not stalled, device by device; i_last_in_device closes a device and
//   i_last_in_pack the scan; output channel (o_valid / i_stall) gives one
//   summary beat per pack scan, on the i_last_in_pack beat; others give none
//   the summary passes the input register, three scaling stages, summary
//   snapshot, average product and result register; one cell beat per cycle
//   while o_stall is low, set by the single accumulator update step; divides
//   are pipelined multiplies by constant reciprocals, at most one per stage
//   the beat after a pack end starts a new scan
//   reset (i_rst_n low, synchronous) empties the pipeline and arms scan start
//   while the receiver stalls, the summary beat holds in the result register;
//   input beats keep flowing until every stage in front of it is full, then
//   o_stall rises
// ----------------------------------------------------------------------------
module battery_pack_cell_statistics_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bpcs_pkg::RAW_W-1:0]    i_raw_code,
    input  logic [bpcs_pkg::CRC_W-1:0]    i_device_crc_errors,
    input  logic                          i_last_in_device,
    input  logic                          i_last_in_pack,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bpcs_pkg::SUM_W-1:0]    o_pack_millivolts,
    output logic [bpcs_pkg::AVG_W-1:0]    o_average_millivolts,
    output logic [bpcs_pkg::MV_W-1:0]     o_lowest_millivolts,
    output logic [bpcs_pkg::MV_W-1:0]     o_highest_millivolts,
    output logic [bpcs_pkg::NUM_W-1:0]    o_lowest_number,
    output logic [bpcs_pkg::NUM_W-1:0]    o_highest_number,
    output logic [bpcs_pkg::CRC_W-1:0]    o_worst_crc_count,
    output logic [bpcs_pkg::DEV_W-1:0]    o_worst_crc_device
);
    import bpcs_pkg::*;

    logic      r_v1, ld1;
    t_cell_raw r_in;
    logic      scl_stall, mv_valid, st_stall;
    t_cell_mv  mv_cell;
    t_stats    stats;

    // input capture stage
    assign ld1     = !r_v1 || !scl_stall;
    assign o_stall = !ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (ld1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_in.raw      <= i_raw_code;
            r_in.crc      <= i_device_crc_errors;
            r_in.dev_end  <= i_last_in_device;
            r_in.pack_end <= i_last_in_pack;
        end
    end

    // code to millivolts
    bpcs_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .o_stall (scl_stall),
        .i_cell  (r_in),
        .o_valid (mv_valid),
        .i_stall (st_stall),
        .o_cell  (mv_cell)
    );

    // accumulators and summary
    bpcs_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mv_valid),
        .o_stall (st_stall),
        .i_cell  (mv_cell),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_stats (stats),
        .o_avg   (o_average_millivolts)
    );

    assign o_pack_millivolts    = stats.sum;
    assign o_lowest_millivolts  = stats.low;
    assign o_highest_millivolts = stats.high;
    assign o_lowest_number      = stats.low_num;
    assign o_highest_number     = stats.high_num;
    assign o_worst_crc_count    = stats.crc_best;
    assign o_worst_crc_device   = stats.crc_dev;

endmodule

@@ src/bpcs_checker.sv @@
// ----------------------------------------------------------------------------
// bpcs_checker
// port-level assertions for the cell statistics block, bound to the top level
// ----------------------------------------------------------------------------
`include "battery_pack_cell_statistics_top_assert.svh"

module bpcs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [bpcs_pkg::SUM_W-1:0]    o_pack_millivolts,
    input logic [bpcs_pkg::AVG_W-1:0]    o_average_millivolts,
    input logic [bpcs_pkg::MV_W-1:0]     o_lowest_millivolts,
    input logic [bpcs_pkg::MV_W-1:0]     o_highest_millivolts,
    input logic [bpcs_pkg::DEV_W-1:0]    o_worst_crc_device
);
    import bpcs_pkg::*;

    // a stalled summary beat stays offered
    `BPCS_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, o_valid && i_stall, o_valid, "summary beat dropped while stalled")

    // a stalled summary beat keeps its sum and average
    `BPCS_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, o_valid && i_stall, $stable(o_pack_millivolts) && $stable(o_average_millivolts), "summary beat changed while stalled")

    // extremes are ordered
    `BPCS_ASSERT_NOW(a_low_le_high, i_clk, i_rst_n, o_valid, o_lowest_millivolts <= o_highest_millivolts, "lowest cell above highest cell")

    // the average never exceeds the pack sum
    `BPCS_ASSERT_NOW(a_avg_le_sum, i_clk, i_rst_n, o_valid, SUM_W'(o_average_millivolts) <= o_pack_millivolts, "average above pack sum")

    // the worst device is a real device
    `BPCS_ASSERT_NOW(a_dev_range, i_clk, i_rst_n, o_valid, o_worst_crc_device <= DEV_LAST, "worst crc device out of range")

endmodule

bind battery_pack_cell_statistics_top bpcs_checker u_bpcs_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_valid              (o_valid),
    .i_stall              (i_stall),
    .o_pack_millivolts    (o_pack_millivolts),
    .o_average_millivolts (o_average_millivolts),
    .o_lowest_millivolts  (o_lowest_millivolts),
    .o_highest_millivolts (o_highest_millivolts),
    .o_worst_crc_device   (o_worst_crc_device)
);
